FILE: rtl/core/tsc_pkg.sv
// tsc_pkg: widths, fixed-point constants and the item type shared by the
// sine/cosine series pipeline. No dependencies.
package tsc_pkg;

  localparam int ANGLE_W   = 17;
  localparam int VALUE_W   = 18;
  localparam int MAG_W     = 17;
  localparam int TERMS_DEF = 8;

  localparam logic OP_SIN = 1'b0;
  localparam logic OP_COS = 1'b1;

  localparam logic [MAG_W-1:0] ANGLE_LIMIT = 17'd46080;

  // Q28 series arithmetic
  localparam int FRAC   = 28;
  localparam int R_W    = 30;
  localparam int X2_W   = 32;
  localparam int TERM_W = 31;
  localparam int SUM_W  = 34;

  // degrees -> radians: r = mag*RAD_INT + floor((mag*RAD_REM + RAD_BIAS) / RAD_DIV)
  localparam int Y_W    = 35;
  localparam int BASE_W = 32;
  localparam int QE_W   = 15;
  localparam logic [14:0] RAD_INT   = 15'd18301;
  localparam logic [17:0] RAD_REM   = 18'd140414;
  localparam logic [19:0] RAD_BIAS  = 20'd703125;
  localparam logic [20:0] RAD_DIV   = 21'd1406250;
  // floor(2^42 / RAD_DIV), applied to y >> RAD_SHIFT
  localparam logic [21:0] RAD_RECIP       = 22'd3127499;
  localparam int          RAD_SHIFT       = 10;
  localparam int          RAD_RECIP_SHIFT = 32;

  // Q28 -> Q16 output
  localparam int               RND_SHIFT = FRAC - 16;
  localparam logic [16:0]      ONE_OUT   = 17'd65536;

  typedef struct packed {
    logic                     op;
    logic                     neg;
    logic                     oor;
    logic [X2_W-1:0]          x2;
    logic [TERM_W-1:0]        term;
    logic signed [SUM_W-1:0]  sum;
  } tsc_item_t;

  // trailing zero count of a small constant
  function automatic int ctz(input int d);
    int   n;
    logic done;
    n    = 0;
    done = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!done) begin
        if (d[i]) begin
          done = 1'b1;
        end else begin
          n = n + 1;
        end
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/tsc_front.sv
// tsc_front: six-stage front end. Folds the angle, converts it to Q28 radians,
// squares it and builds the first series item. Depends on tsc_pkg.
module tsc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               feed_valid,
  output logic                               feed_ready,
  input  logic                               feed_op,
  input  logic signed [tsc_pkg::ANGLE_W-1:0] feed_angle,
  output logic                               pass_valid,
  input  logic                               pass_ready,
  output tsc_pkg::tsc_item_t                 pass_item
);
  import tsc_pkg::*;

  localparam int STAGES = 6;
  localparam int YH_W   = Y_W - RAD_SHIFT;
  localparam int RP_W   = YH_W + $bits(RAD_RECIP);
  localparam int SQ_W   = 2 * R_W;

  logic [STAGES-1:0] v;
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] v_in;

  assign rdy[STAGES] = pass_ready;
  for (genvar i = 0; i < STAGES; i++) begin : g_rdy
    assign rdy[i] = !v[i] || rdy[i+1];
  end
  assign feed_ready = rdy[0];
  assign v_in       = {v[STAGES-2:0], feed_valid};
  assign pass_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  // stage 0: fold sign, range check
  logic [MAG_W-1:0] ang_bits, mag_c, mag0;
  logic             op0, neg0, oor0;
  assign ang_bits = feed_angle;
  assign mag_c    = ang_bits[MAG_W-1] ? (~ang_bits + 1'b1) : ang_bits;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      op0  <= feed_op;
      neg0 <= ang_bits[MAG_W-1];
      oor0 <= mag_c > ANGLE_LIMIT;
      mag0 <= mag_c;
    end
  end

  // stage 1: integer part and remainder numerator of the conversion
  logic [Y_W-1:0]    y1;
  logic [BASE_W-1:0] base1;
  logic              op1, neg1, oor1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      y1    <= Y_W'(mag0) * Y_W'(RAD_REM) + Y_W'(RAD_BIAS);
      base1 <= BASE_W'(mag0) * BASE_W'(RAD_INT);
      op1   <= op0;
      neg1  <= neg0;
      oor1  <= oor0;
    end
  end

  // stage 2: quotient estimate by reciprocal, low by at most one
  logic [RP_W-1:0]   rp_c;
  logic [Y_W-1:0]    y2;
  logic [BASE_W-1:0] base2;
  logic [QE_W-1:0]   qe2;
  logic              op2, neg2, oor2;
  assign rp_c = RP_W'(y1[Y_W-1:RAD_SHIFT]) * RP_W'(RAD_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      qe2   <= QE_W'(rp_c >> RAD_RECIP_SHIFT);
      y2    <= y1;
      base2 <= base1;
      op2   <= op1;
      neg2  <= neg1;
      oor2  <= oor1;
    end
  end

  // stage 3: remainder
  logic [Y_W-1:0]    rem3;
  logic [BASE_W-1:0] base3;
  logic [QE_W-1:0]   qe3;
  logic              op3, neg3, oor3;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rem3  <= y2 - Y_W'(qe2) * Y_W'(RAD_DIV);
      qe3   <= qe2;
      base3 <= base2;
      op3   <= op2;
      neg3  <= neg2;
      oor3  <= oor2;
    end
  end

  // stage 4: corrected radians, Q28
  logic [BASE_W-1:0] r_sum;
  logic [R_W-1:0]    r4;
  logic              op4, neg4, oor4;
  assign r_sum = base3 + BASE_W'(qe3) + BASE_W'(rem3 >= Y_W'(RAD_DIV));

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      r4   <= R_W'(r_sum);
      op4  <= op3;
      neg4 <= neg3;
      oor4 <= oor3;
    end
  end

  // stage 5: square, first term
  logic [SQ_W-1:0]   sq_c;
  logic [TERM_W-1:0] t0_c;
  assign sq_c = SQ_W'(r4) * SQ_W'(r4) + (SQ_W'(1) << (FRAC - 1));
  assign t0_c = (op4 == OP_COS) ? (TERM_W'(1) << FRAC) : TERM_W'(r4);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      pass_item.op   <= op4;
      pass_item.neg  <= neg4;
      pass_item.oor  <= oor4;
      pass_item.x2   <= sq_c[FRAC+X2_W-1:FRAC];
      pass_item.term <= t0_c;
      pass_item.sum  <= signed'(SUM_W'(t0_c));
    end
  end

endmodule

FILE: rtl/core/tsc_cell.sv
// tsc_cell: one series term, three stages. Forms t_k from t_{k-1} and x^2 with
// a rounded divide by the term's constant, and adds it to (even K) or subtracts
// it from (odd K) the running sum. Depends on tsc_pkg.
module tsc_cell #(
  parameter int K = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               feed_valid,
  output logic               feed_ready,
  input  tsc_pkg::tsc_item_t feed_item,
  output logic               pass_valid,
  input  logic               pass_ready,
  output tsc_pkg::tsc_item_t pass_item
);
  import tsc_pkg::*;

  localparam int STAGES = 3;
  localparam int P_W    = TERM_W + X2_W;
  localparam int WS_W   = 64;
  localparam int W_W    = WS_W - FRAC;
  localparam int WSH_W  = 33;
  localparam int QE_W_C = 32;
  localparam int REM_W  = 42;

  // divisor d = 2^e * o, o odd; o is divided by reciprocal floor(2^33 / o)
  localparam int D_SIN = (2 * K) * (2 * K + 1);
  localparam int D_COS = (2 * K - 1) * (2 * K);
  localparam int E_SIN = ctz(D_SIN);
  localparam int E_COS = ctz(D_COS);
  localparam int O_SIN = D_SIN >> E_SIN;
  localparam int O_COS = D_COS >> E_COS;
  localparam logic [31:0] M_SIN = 32'((longint'(1) << 33) / O_SIN);
  localparam logic [31:0] M_COS = 32'((longint'(1) << 33) / O_COS);
  localparam logic ONE_SIN  = (O_SIN == 1);
  localparam logic ONE_COS  = (O_COS == 1);
  localparam logic SUBTRACT = K[0];

  logic [STAGES-1:0] v;
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] v_in;

  assign rdy[STAGES] = pass_ready;
  for (genvar i = 0; i < STAGES; i++) begin : g_rdy
    assign rdy[i] = !v[i] || rdy[i+1];
  end
  assign feed_ready = rdy[0];
  assign v_in       = {v[STAGES-2:0], feed_valid};
  assign pass_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  // stage 1: t * x^2
  logic [P_W-1:0] p1;
  tsc_item_t      it1;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1  <= P_W'(feed_item.term) * P_W'(feed_item.x2);
      it1 <= feed_item;
    end
  end

  // stage 2: round and drop 2^28 and 2^e, then quotient estimate (low by up to two)
  logic              is_cos2;
  logic [WS_W-1:0]   d_sel, wsum;
  logic [W_W-1:0]    w_c, wsh_c;
  logic [WSH_W-1:0]  wsh_t;
  logic [31:0]       m_sel;
  logic              one_sel;
  logic [63:0]       est_c;
  logic [QE_W_C-1:0] qe_c, qe2;
  logic [WSH_W-1:0]  wsh2;
  tsc_item_t         it2;

  assign is_cos2 = (it1.op == OP_COS);
  assign d_sel   = is_cos2 ? WS_W'(D_COS) : WS_W'(D_SIN);
  assign wsum    = WS_W'(p1) + (d_sel << (FRAC - 1));
  assign w_c     = wsum[WS_W-1:FRAC];
  assign wsh_c   = is_cos2 ? (w_c >> E_COS) : (w_c >> E_SIN);
  assign wsh_t   = wsh_c[WSH_W-1:0];
  assign m_sel   = is_cos2 ? M_COS : M_SIN;
  assign one_sel = is_cos2 ? ONE_COS : ONE_SIN;
  assign est_c   = 64'(wsh_t[WSH_W-1:1]) * 64'(m_sel);
  assign qe_c    = one_sel ? QE_W_C'(wsh_t) : est_c[63:32];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      qe2  <= qe_c;
      wsh2 <= wsh_t;
      it2  <= it1;
    end
  end

  // stage 3: remainder correction and accumulate
  logic [REM_W-1:0]        o_sel, rem_c;
  logic [QE_W_C:0]         q_c;
  logic [TERM_W-1:0]       t_c;
  logic signed [SUM_W-1:0] t_ext;
  tsc_item_t               pass_item_next;

  assign o_sel = (it2.op == OP_COS) ? REM_W'(O_COS) : REM_W'(O_SIN);
  assign rem_c = REM_W'(wsh2) - REM_W'(qe2) * o_sel;
  assign q_c   = (QE_W_C + 1)'(qe2) + (QE_W_C + 1)'(rem_c >= o_sel)
               + (QE_W_C + 1)'(rem_c >= (o_sel << 1));
  assign t_c   = q_c[TERM_W-1:0];
  assign t_ext = signed'(SUM_W'(t_c));

  always_comb begin
    pass_item_next      = it2;
    pass_item_next.term = t_c;
    pass_item_next.sum  = SUBTRACT ? (it2.sum - t_ext) : (it2.sum + t_ext);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      pass_item <= pass_item_next;
    end
  end

endmodule

FILE: rtl/core/tsc_out.sv
// tsc_out: sign fix-up, Q28 -> Q16 rounding (halves away from zero),
// saturation and the output register. Depends on tsc_pkg.
module tsc_out (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               feed_valid,
  output logic                               feed_ready,
  input  tsc_pkg::tsc_item_t                 feed_item,
  output logic                               pass_valid,
  input  logic                               pass_ready,
  output logic signed [tsc_pkg::VALUE_W-1:0] value,
  output logic                               out_of_range
);
  import tsc_pkg::*;

  localparam int ABS_W = SUM_W - 1;
  localparam int RS_W  = SUM_W;
  localparam int RND_W = RS_W - RND_SHIFT;
  localparam int MO_W  = $bits(ONE_OUT);

  logic [1:0] v;
  logic [2:0] rdy;

  assign rdy[2] = pass_ready;
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign feed_ready = rdy[0];
  assign pass_valid = v[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= feed_valid;
      end
      if (rdy[1]) begin
        v[1] <= v[0];
      end
    end
  end

  // stage 1: magnitude and result sign; negative sine angles flip the sign
  logic [SUM_W-1:0] neg_sum;
  logic [ABS_W-1:0] abs1;
  logic             sgn1, oor1;
  assign neg_sum = -feed_item.sum;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      abs1 <= feed_item.sum[SUM_W-1] ? neg_sum[ABS_W-1:0] : feed_item.sum[ABS_W-1:0];
      sgn1 <= feed_item.sum[SUM_W-1] ^ ((feed_item.op == OP_SIN) && feed_item.neg);
      oor1 <= feed_item.oor;
    end
  end

  // stage 2: round, clamp, output register
  logic [RS_W-1:0]    rs_c;
  logic [RND_W-1:0]   rnd_c;
  logic [MO_W-1:0]    mag_c;
  logic [VALUE_W-1:0] val_c;
  assign rs_c  = RS_W'(abs1) + (RS_W'(1) << (RND_SHIFT - 1));
  assign rnd_c = rs_c[RS_W-1:RND_SHIFT];
  assign mag_c = (rnd_c > RND_W'(ONE_OUT)) ? ONE_OUT : rnd_c[MO_W-1:0];
  assign val_c = sgn1 ? (-VALUE_W'(mag_c)) : VALUE_W'(mag_c);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      value        <= oor1 ? '0 : signed'(val_c);
      out_of_range <= oor1;
    end
  end

endmodule

FILE: rtl/core/taylor_sine_cosine_degrees.sv
// Sine or cosine of an angle in degrees by a truncated Taylor series.
// Channels: the angle channel (angle_valid, angle_stall, op, angle_deg) and
// the result channel (result_valid, result_stall, value, out_of_range).
// A transfer happens on a rising edge with valid high and stall low.
// angle_deg is signed Q8 degrees; op selects sine (0) or cosine (1).
// value is signed Q16; beyond +/-180 degrees out_of_range is set and value
// is zero.
// Throughput: one transfer per cycle on each side while result_stall is low.
// An angle passes through six front-end stages (folding, degree-to-radian
// conversion, square), a chain of TERMS-1 term cells of three stages each,
// and two output stages.
// Every stage holds its own valid bit; a stage loads whenever it is empty
// or the next one moves, so bubbles close up while the output is stalled.
// With the receiver stalled the result register holds; angle_stall rises
// only once every stage in the chain is full.
// Reset (rst, synchronous) clears the valid bits; data registers are not reset.
// Depends on tsc_pkg, tsc_front, tsc_cell, tsc_out.
module taylor_sine_cosine_degrees #(
  parameter int TERMS = tsc_pkg::TERMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               angle_valid,
  output logic                               angle_stall,
  input  logic                               op,
  input  logic signed [tsc_pkg::ANGLE_W-1:0] angle_deg,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [tsc_pkg::VALUE_W-1:0] value,
  output logic                               out_of_range
);
  import tsc_pkg::*;

  tsc_item_t  chain_item  [TERMS];
  logic       chain_valid [TERMS];
  logic       chain_ready [TERMS];
  logic       front_ready;
  logic       out_ready;

  assign angle_stall = !front_ready;

  tsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (angle_valid),
    .feed_ready (front_ready),
    .feed_op    (op),
    .feed_angle (angle_deg),
    .pass_valid (chain_valid[0]),
    .pass_ready (chain_ready[0]),
    .pass_item  (chain_item[0])
  );

  for (genvar k = 1; k < TERMS; k++) begin : g_cell
    tsc_cell #(
      .K (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .feed_valid (chain_valid[k-1]),
      .feed_ready (chain_ready[k-1]),
      .feed_item  (chain_item[k-1]),
      .pass_valid (chain_valid[k]),
      .pass_ready (chain_ready[k]),
      .pass_item  (chain_item[k])
    );
  end

  assign chain_ready[TERMS-1] = out_ready;

  tsc_out u_out (
    .clk          (clk),
    .rst          (rst),
    .feed_valid   (chain_valid[TERMS-1]),
    .feed_ready   (out_ready),
    .feed_item    (chain_item[TERMS-1]),
    .pass_valid   (result_valid),
    .pass_ready   (!result_stall),
    .value        (value),
    .out_of_range (out_of_range)
  );

endmodule

FILE: rtl/core/tsc_checker.sv
// tsc_checker: port-level checks for taylor_sine_cosine_degrees, attached by
// the bind below. Depends on tsc_pkg.
module tsc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               angle_valid,
  input logic                               angle_stall,
  input logic                               op,
  input logic signed [tsc_pkg::ANGLE_W-1:0] angle_deg,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic signed [tsc_pkg::VALUE_W-1:0] value,
  input logic                               out_of_range
);
  import tsc_pkg::*;

  // pipeline comes out of reset empty
  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result_valid high right after reset");

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(value) && $stable(out_of_range))
    else $error("result payload changed while stalled");

  a_oor_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && out_of_range |-> value == '0)
    else $error("out-of-range result with nonzero value");

  a_saturated : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> value <= signed'(VALUE_W'(ONE_OUT))
                  && value >= -signed'(VALUE_W'(ONE_OUT)))
    else $error("value beyond +/-1.0");

endmodule

bind taylor_sine_cosine_degrees tsc_checker u_tsc_checker (.*);
